@@ design/crid_pkg.sv @@
`timescale 1ns / 1ps

package crid_pkg;

   // CIGAR operation codes
   localparam logic [3:0] KIND_M  = 4'd0;
   localparam logic [3:0] KIND_I  = 4'd1;
   localparam logic [3:0] KIND_D  = 4'd2;
   localparam logic [3:0] KIND_EQ = 4'd7;
   localparam logic [3:0] KIND_X  = 4'd8;

   // configuration register indexes
   localparam logic CSR_REGION_FIRST = 1'b0;
   localparam logic CSR_REGION_FINAL = 1'b1;

   localparam logic [31:0] INT32_MAX_BITS = 32'h7fff_ffff;
   localparam logic [31:0] INT32_MIN_BITS = 32'h8000_0000;

   typedef struct packed {
      logic [3:0]  op_kind;
      logic [27:0] op_length;
      logic [30:0] read_begin;
      logic        final_op;
   } req_type;

   typedef struct packed {
      logic               found;
      logic signed [31:0] indel_diff;
   } rsp_type;

   typedef struct packed {
      logic [3:0]  op_kind;
      logic [27:0] op_length;
   } op_entry_type;

   typedef enum logic [3:0] {
      ST_IDLE,
      ST_SPAN,
      ST_CHECK,
      ST_FWD,
      ST_BWD,
      ST_SUM,
      ST_DONE
   } state_type;

   function automatic logic is_match(input logic [3:0] kind);
      return (kind == KIND_M) || (kind == KIND_EQ) || (kind == KIND_X);
   endfunction

   function automatic logic advances(input logic [3:0] kind);
      return is_match(kind) || (kind == KIND_D);
   endfunction

endpackage

@@ design/crid_store.sv @@
`timescale 1ns / 1ps

module crid_store #(
   parameter int DEPTH = 64,
   localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
   input  logic                  clock,
   input  logic                  wr_en,
   input  logic [AW-1:0]         wr_addr,
   input  crid_pkg::op_entry_type wr_data,
   input  logic [AW-1:0]         rd_addr,
   output crid_pkg::op_entry_type rd_data
);
   import crid_pkg::*;

   op_entry_type mem [DEPTH];
   op_entry_type rd_data_ff;

   // write port
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
   end

   // registered read port
   always_ff @(posedge clock) begin
      rd_data_ff <= mem[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

@@ design/cigar_region_indel_length_unit.sv @@
`timescale 1ns / 1ps
// CIGAR region indel length unit.
//
// req channel: one CIGAR operation per transaction (kind, length, read start,
// final flag). The read start is taken from the first operation of a read.
// Operations past MAX_OPS are dropped and the read then reports not found.
// A non-final operation is stored and the unit stays ready for the next one.
// On the final operation the unit stalls req while a sequencer walks the
// stored operations through one registered memory read port: a span pass
// over all ops, a forward scan, a backward scan and a sum over the
// selected ops.
// rsp channel: one transaction per read with found and the saturated
// inserted-minus-deleted count. A result held by rsp_stall keeps the unit in
// its done state until taken; operations are accepted again after that.
// csr port: region_first (index 0) and region_final (index 1); write them
// only while the unit is idle.
// Reset (synchronous) empties the op list and drops any pending result;
// the op memory needs no clearing since only written entries are read.

module cigar_region_indel_length_unit #(
   parameter int MAX_OPS = 64
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   output logic              req_stall,
   input  crid_pkg::req_type req_data,
   output logic              rsp_valid,
   input  logic              rsp_stall,
   output crid_pkg::rsp_type rsp_data,
   input  logic              csr_wr_en,
   input  logic              csr_index,
   input  logic [30:0]       csr_wdata
);
   import crid_pkg::*;

   localparam int AW = (MAX_OPS > 1) ? $clog2(MAX_OPS) : 1;   // op index width
   localparam int CW = $clog2(MAX_OPS + 1);                  // op count width
   localparam int PW = 32 + AW;                              // position / span width
   localparam int DW = 30 + AW;                              // signed difference width
   localparam int SW = (DW > 32) ? DW : 32;
   localparam logic signed [SW-1:0] SAT_HI = SW'($signed(INT32_MAX_BITS));
   localparam logic signed [SW-1:0] SAT_LO = SW'($signed(INT32_MIN_BITS));

   // control state
   state_type         state_ff, state_in;
   logic              step_ff, step_in;
   logic [CW-1:0]     count_ff, count_in;
   logic              overflow_ff, overflow_in;
   logic [30:0]       origin_ff, origin_in;
   logic [30:0]       region_first_ff, region_first_in;
   logic [30:0]       region_final_ff, region_final_in;
   logic              rsp_valid_ff, rsp_valid_in;

   // datapath state
   logic [AW-1:0]     idx_ff, idx_in;
   logic [AW-1:0]     last_idx_ff, last_idx_in;
   logic [AW-1:0]     first_idx_ff, first_idx_in;
   logic [AW-1:0]     end_idx_ff, end_idx_in;
   logic [AW-1:0]     mark_ff, mark_in;
   logic [PW-1:0]     span_ff, span_in;
   logic [PW-1:0]     pos_ff, pos_in;
   logic signed [DW-1:0] diff_ff, diff_in;
   logic              op0_match_ff, op0_match_in;
   logic              opn_match_ff, opn_match_in;
   logic              found_ff, found_in;
   rsp_type           rsp_data_ff, rsp_data_in;

   // memory interface
   logic              wr_en;
   op_entry_type      wr_entry;
   op_entry_type      op_rd;

   // shared-unit helpers
   logic [PW-1:0]     len_ext;
   logic              rd_match;
   logic              rd_adv;
   logic [AW-1:0]     mark_nx;
   logic              fwd_exit;
   logic [AW-1:0]     fwd_first;
   logic              bwd_exit;
   logic [AW-1:0]     bwd_end;
   logic signed [SW-1:0] diff_ext;
   logic [31:0]       diff_sat;

   crid_store #(
      .DEPTH (MAX_OPS)
   ) u_store (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (count_ff[AW-1:0]),
      .wr_data (wr_entry),
      .rd_addr (idx_ff),
      .rd_data (op_rd)
   );

   assign wr_entry.op_kind   = req_data.op_kind;
   assign wr_entry.op_length = req_data.op_length;

   assign len_ext  = PW'(op_rd.op_length);
   assign rd_match = is_match(op_rd.op_kind);
   assign rd_adv   = advances(op_rd.op_kind);
   assign mark_nx  = rd_match ? idx_ff : mark_ff;

   // clamp the wide difference to 32-bit two's complement
   assign diff_ext = SW'(diff_ff);
   always_comb begin
      if (diff_ext > SAT_HI) begin
         diff_sat = INT32_MAX_BITS;
      end else if (diff_ext < SAT_LO) begin
         diff_sat = INT32_MIN_BITS;
      end else begin
         diff_sat = diff_ext[31:0];
      end
   end

   always_comb begin
      state_in        = state_ff;
      step_in         = step_ff;
      count_in        = count_ff;
      overflow_in     = overflow_ff;
      origin_in       = origin_ff;
      region_first_in = region_first_ff;
      region_final_in = region_final_ff;
      rsp_valid_in    = rsp_valid_ff;
      idx_in          = idx_ff;
      last_idx_in     = last_idx_ff;
      first_idx_in    = first_idx_ff;
      end_idx_in      = end_idx_ff;
      mark_in         = mark_ff;
      span_in         = span_ff;
      pos_in          = pos_ff;
      diff_in         = diff_ff;
      op0_match_in    = op0_match_ff;
      opn_match_in    = opn_match_ff;
      found_in        = found_ff;
      rsp_data_in     = rsp_data_ff;
      wr_en           = 1'b0;
      fwd_exit        = 1'b0;
      fwd_first       = mark_ff;
      bwd_exit        = 1'b0;
      bwd_end         = mark_ff;
      req_stall       = (state_ff != ST_IDLE);

      // region registers
      if (csr_wr_en) begin
         unique case (csr_index)
            CSR_REGION_FIRST: region_first_in = csr_wdata;
            CSR_REGION_FINAL: region_final_in = csr_wdata;
            default: ;
         endcase
      end

      // drop the result once the receiver takes it
      if (rsp_valid_ff && !rsp_stall) begin
         rsp_valid_in = 1'b0;
      end

      unique case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               if ((count_ff == '0) && !overflow_ff) begin
                  origin_in = req_data.read_begin;
               end
               if (count_ff < CW'(MAX_OPS)) begin
                  wr_en    = 1'b1;
                  count_in = count_ff + CW'(1);
               end else begin
                  overflow_in = 1'b1;
               end
               if (req_data.final_op) begin
                  count_in    = '0;
                  overflow_in = 1'b0;
                  last_idx_in = count_ff[AW-1:0];
                  idx_in      = '0;
                  step_in     = 1'b0;
                  span_in     = '0;
                  if (overflow_ff || (count_ff == CW'(MAX_OPS))) begin
                     found_in = 1'b0;
                     diff_in  = '0;
                     state_in = ST_DONE;
                  end else begin
                     state_in = ST_SPAN;
                  end
               end
            end
         end

         // total reference span, and note whether the edge ops are matches
         ST_SPAN: begin
            if (!step_ff) begin
               step_in = 1'b1;
            end else begin
               step_in = 1'b0;
               if (rd_adv) begin
                  span_in = span_ff + len_ext;
               end
               if (idx_ff == '0) begin
                  op0_match_in = rd_match;
               end
               if (idx_ff == last_idx_ff) begin
                  opn_match_in = rd_match;
                  state_in     = ST_CHECK;
               end else begin
                  idx_in = idx_ff + AW'(1);
               end
            end
         end

         // region must lie inside [origin, origin + span)
         ST_CHECK: begin
            if ((PW'(region_first_ff) < PW'(origin_ff)) ||
                (PW'(region_final_ff) >= PW'(origin_ff) + span_ff)) begin
               found_in = 1'b0;
               diff_in  = '0;
               state_in = ST_DONE;
            end else begin
               pos_in   = PW'(origin_ff);
               idx_in   = '0;
               mark_in  = '0;
               step_in  = 1'b0;
               state_in = ST_FWD;
            end
         end

         // advance to the last match starting before the region
         ST_FWD: begin
            if (!step_ff) begin
               if (pos_ff >= PW'(region_first_ff)) begin
                  fwd_exit  = 1'b1;
                  fwd_first = mark_ff;
               end else begin
                  step_in = 1'b1;
               end
            end else begin
               step_in = 1'b0;
               mark_in = mark_nx;
               if (rd_adv) begin
                  pos_in = pos_ff + len_ext;
               end
               if (idx_ff == last_idx_ff) begin
                  fwd_exit  = 1'b1;
                  fwd_first = mark_nx;
               end else begin
                  idx_in = idx_ff + AW'(1);
               end
            end
         end

         // walk back to the first match ending after the region
         ST_BWD: begin
            if (!step_ff) begin
               if (pos_ff <= PW'(region_final_ff)) begin
                  bwd_exit = 1'b1;
                  bwd_end  = mark_ff;
               end else begin
                  step_in = 1'b1;
               end
            end else begin
               step_in = 1'b0;
               mark_in = mark_nx;
               if (rd_adv) begin
                  pos_in = (pos_ff >= len_ext) ? (pos_ff - len_ext) : '0;
               end
               if (idx_ff == '0) begin
                  bwd_exit = 1'b1;
                  bwd_end  = mark_nx;
               end else begin
                  idx_in = idx_ff - AW'(1);
               end
            end
         end

         // accumulate inserted minus deleted bases
         ST_SUM: begin
            if (!step_ff) begin
               step_in = 1'b1;
            end else begin
               step_in = 1'b0;
               priority if (op_rd.op_kind == KIND_D) begin
                  diff_in = diff_ff - $signed(DW'(op_rd.op_length));
               end else if (op_rd.op_kind == KIND_I) begin
                  diff_in = diff_ff + $signed(DW'(op_rd.op_length));
               end
               if (idx_ff == end_idx_ff) begin
                  found_in = 1'b1;
                  state_in = ST_DONE;
               end else begin
                  idx_in = idx_ff + AW'(1);
               end
            end
         end

         // hold until the output register is free
         ST_DONE: begin
            if (!rsp_valid_ff || !rsp_stall) begin
               rsp_valid_in           = 1'b1;
               rsp_data_in.found      = found_ff;
               rsp_data_in.indel_diff = diff_sat;
               state_in               = ST_IDLE;
            end
         end

         default: state_in = ST_IDLE;
      endcase

      // forward scan done: reject a trim onto a non-match first op
      if (fwd_exit) begin
         if ((fwd_first == '0) && !op0_match_ff) begin
            found_in = 1'b0;
            diff_in  = '0;
            state_in = ST_DONE;
         end else begin
            first_idx_in = fwd_first;
            pos_in       = PW'(origin_ff) + span_ff;
            idx_in       = last_idx_ff;
            mark_in      = last_idx_ff;
            step_in      = 1'b0;
            state_in     = ST_BWD;
         end
      end

      // backward scan done: reject a trim onto a non-match last op
      if (bwd_exit) begin
         if ((bwd_end == last_idx_ff) && !opn_match_ff) begin
            found_in = 1'b0;
            diff_in  = '0;
            state_in = ST_DONE;
         end else if (first_idx_ff > bwd_end) begin
            // empty range: found with no difference
            found_in = 1'b1;
            diff_in  = '0;
            state_in = ST_DONE;
         end else begin
            end_idx_in = bwd_end;
            idx_in     = first_idx_ff;
            diff_in    = '0;
            step_in    = 1'b0;
            state_in   = ST_SUM;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff        <= ST_IDLE;
         step_ff         <= 1'b0;
         count_ff        <= '0;
         overflow_ff     <= 1'b0;
         origin_ff       <= '0;
         region_first_ff <= '0;
         region_final_ff <= '0;
         rsp_valid_ff    <= 1'b0;
      end else begin
         state_ff        <= state_in;
         step_ff         <= step_in;
         count_ff        <= count_in;
         overflow_ff     <= overflow_in;
         origin_ff       <= origin_in;
         region_first_ff <= region_first_in;
         region_final_ff <= region_final_in;
         rsp_valid_ff    <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      idx_ff       <= idx_in;
      last_idx_ff  <= last_idx_in;
      first_idx_ff <= first_idx_in;
      end_idx_ff   <= end_idx_in;
      mark_ff      <= mark_in;
      span_ff      <= span_in;
      pos_ff       <= pos_in;
      diff_ff      <= diff_in;
      op0_match_ff <= op0_match_in;
      opn_match_ff <= opn_match_in;
      found_ff     <= found_in;
      rsp_data_ff  <= rsp_data_in;
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

   // op count never passes the memory depth
   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= CW'(MAX_OPS))
      else $error("op count beyond memory depth");

   // a failed read reports a zero difference
   a_fail_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_data.found |-> rsp_data.indel_diff == '0)
      else $error("failed result with nonzero difference");

   // a new result only comes out of the done state
   a_rsp_from_done: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid_ff) |-> $past(state_ff == ST_DONE))
      else $error("result raised outside done state");

   // the sum pass stays inside the selected op range
   a_sum_range: assert property (@(posedge clock) disable iff (reset)
      state_ff == ST_SUM |-> (idx_ff >= first_idx_ff) && (idx_ff <= end_idx_ff))
      else $error("sum index outside selected range");

endmodule

@@ bench/tb_cigar_region_indel_length_unit.sv @@
`timescale 1ns / 1ps

module tb_cigar_region_indel_length_unit;
   import crid_pkg::*;

   localparam int OP_CAPACITY = 64;

   // CIGAR codes that the package leaves unnamed, and one code outside CIGAR
   localparam logic [3:0] OP_N = 4'd3;
   localparam logic [3:0] OP_S = 4'd4;
   localparam logic [3:0] OP_H = 4'd5;
   localparam logic [3:0] OP_P = 4'd6;
   localparam logic [3:0] OP_ANY = 4'hf;

   localparam logic [27:0] LEN_MAX = 28'hfff_ffff;
   localparam logic [30:0] POS_MAX = 31'h7fff_ffff;

   // Sizing for the random part
   localparam int PHASES = 8;
   localparam int OPS_PER_PHASE = 212;
   // Covers the longest walk after a final op, rounded up
   localparam int DRAIN_CYCLES = 600;

   logic    clock;
   logic    reset;
   logic    req_valid;
   logic    req_stall;
   req_type req_data;
   logic    rsp_valid;
   logic    rsp_stall;
   rsp_type rsp_data;
   logic    csr_wr_en;
   logic    csr_index;
   logic [30:0] csr_wdata;

   cigar_region_indel_length_unit #(
      .MAX_OPS(OP_CAPACITY)
   ) dut (
      .clock(clock),
      .reset(reset),
      .req_valid(req_valid),
      .req_stall(req_stall),
      .req_data(req_data),
      .rsp_valid(rsp_valid),
      .rsp_stall(rsp_stall),
      .rsp_data(rsp_data),
      .csr_wr_en(csr_wr_en),
      .csr_index(csr_index),
      .csr_wdata(csr_wdata)
   );

   // One row of the directed script: either a new region window or one op.
   // A pinned row carries its expected result typed in by hand.
   typedef struct {
      bit          is_window;
      logic [30:0] lo;
      logic [30:0] hi;
      req_type     op;
      bit          pinned;
      rsp_type     want;
   } script_row_type;

   script_row_type script[$];
   rsp_type        pending_rsp[$];

   // Bench-side copy of the unit: stored ops, read origin, region window
   logic [3:0]  held_kind[OP_CAPACITY];
   logic [27:0] held_len[OP_CAPACITY];
   int          held_count;
   logic [30:0] origin;
   bit          dropped;
   logic [30:0] win_first;
   logic [30:0] win_last;

   int unsigned fault_count;
   int unsigned ops_sent;
   int unsigned send_gap_pct;
   int unsigned recv_stall_pct;

   // ---------------------------------------------------------------
   // Region indel predictor
   // ---------------------------------------------------------------

   function automatic bit is_aligned(input logic [3:0] k);
      return k == KIND_M || k == KIND_EQ || k == KIND_X;
   endfunction

   function automatic bit moves_ref(input logic [3:0] k);
      return is_aligned(k) || k == KIND_D;
   endfunction

   // Inserted minus deleted bases between the match that opens the window
   // and the match that closes it; found stays low on any failure.
   function automatic rsp_type indel_in_window();
      longint unsigned span;
      longint unsigned pos;
      longint unsigned run_len;
      longint          balance;
      int              idx;
      int              last;
      int              lo;
      int              hi;
      int              i;
      rsp_type         r;
      r.found = 1'b0;
      r.indel_diff = '0;
      span = 0;
      balance = 0;
      if (dropped || held_count == 0) return r;
      for (i = 0; i < held_count; i++)
         if (moves_ref(held_kind[i])) span += held_len[i];
      // region must sit inside [origin, origin + span)
      if (win_first < origin) return r;
      if (win_last >= origin + span) return r;

      // walk forward to the last match starting before the region
      pos = origin;
      idx = 0;
      last = 0;
      while (pos < win_first && idx < held_count) begin
         if (moves_ref(held_kind[idx])) pos += held_len[idx];
         if (is_aligned(held_kind[idx])) last = idx;
         idx++;
      end
      lo = last;
      if (lo == 0 && !is_aligned(held_kind[0])) return r;

      // walk backward to the first match ending after the region
      idx = held_count - 1;
      last = held_count - 1;
      pos = origin + span;
      while (pos > win_last) begin
         if (moves_ref(held_kind[idx])) begin
            run_len = held_len[idx];
            pos = (pos >= run_len) ? pos - run_len : 0;
         end
         if (is_aligned(held_kind[idx])) last = idx;
         if (idx == 0) break;
         idx--;
      end
      hi = last;
      if (hi == held_count - 1 && !is_aligned(held_kind[hi])) return r;

      // an inverted window leaves hi below lo: empty sum, still found
      for (i = lo; i <= hi && i < held_count; i++) begin
         if (held_kind[i] == KIND_D) balance -= longint'(held_len[i]);
         else if (held_kind[i] == KIND_I) balance += longint'(held_len[i]);
      end
      r.found = 1'b1;
      if (balance > 64'sd2147483647) r.indel_diff = INT32_MAX_BITS;
      else if (balance < -64'sd2147483648) r.indel_diff = INT32_MIN_BITS;
      else r.indel_diff = balance[31:0];
      return r;
   endfunction

   // Store one op; on the final op of a read, produce its result and rewind
   function automatic bit absorb_op(input req_type op, output rsp_type res);
      res = '0;
      if (held_count == 0 && !dropped) origin = op.read_begin;
      if (held_count < OP_CAPACITY) begin
         held_kind[held_count] = op.op_kind;
         held_len[held_count] = op.op_length;
         held_count++;
      end else begin
         dropped = 1'b1;
      end
      if (!op.final_op) return 1'b0;
      res = indel_in_window();
      held_count = 0;
      dropped = 1'b0;
      return 1'b1;
   endfunction

   // Queue helpers: append at the tail
   function automatic void add_row(input script_row_type row);
      script = {script, row};
   endfunction

   function automatic void expect_rsp(input rsp_type r);
      pending_rsp = {pending_rsp, r};
   endfunction

   // ---------------------------------------------------------------
   // Script and stimulus helpers
   // ---------------------------------------------------------------

   function automatic script_row_type op_row(input logic [3:0] k, input logic [27:0] len,
                                             input logic [30:0] start_pos, input bit fin,
                                             input bit pinned = 1'b0, input bit hit = 1'b0,
                                             input logic [31:0] diff = '0);
      script_row_type row;
      row = '{default: '0};
      row.op = '{op_kind: k, op_length: len, read_begin: start_pos, final_op: fin};
      row.pinned = pinned;
      row.want.found = hit;
      row.want.indel_diff = diff;
      return row;
   endfunction

   function automatic script_row_type window_row(input logic [30:0] lo,
                                                 input logic [30:0] hi);
      script_row_type row;
      row = '{default: '0};
      row.is_window = 1'b1;
      row.lo = lo;
      row.hi = hi;
      return row;
   endfunction

   function automatic req_type bare_op(input logic [3:0] k, input logic [27:0] len);
      req_type op;
      op = '0;
      op.op_kind = k;
      op.op_length = len;
      return op;
   endfunction

   function automatic logic [3:0] any_match();
      case ($urandom_range(2))
         0: return KIND_M;
         1: return KIND_EQ;
         default: return KIND_X;
      endcase
   endfunction

   function automatic logic [3:0] any_gap();
      case ($urandom_range(7))
         0, 1: return KIND_I;
         2, 3: return KIND_D;
         4: return OP_N;
         5: return OP_P;
         default: return any_match();
      endcase
   endfunction

   // Mostly short runs so that windows land on op edges; some zero,
   // some full-scale, some anywhere in the 28-bit range
   function automatic logic [27:0] any_len();
      int unsigned pick;
      pick = $urandom_range(99);
      if (pick < 5) return '0;
      if (pick < 10) return LEN_MAX;
      if (pick < 15) return 28'($urandom);
      return 28'($urandom_range(30, 1));
   endfunction

   // Offer one op transaction; gap first as the sender mode asks, then hold
   // valid and payload until accepted. Predict once the op is taken.
   task automatic send_op(input req_type op, input bit pinned, input rsp_type pinned_rsp);
      rsp_type guess;
      while (send_gap_pct != 0 && $urandom_range(99) < send_gap_pct) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid <= 1'b1;
      req_data <= op;
      do @(posedge clock); while (req_stall);
      if (absorb_op(op, guess)) expect_rsp(pinned ? pinned_rsp : guess);
      ops_sent++;
   endtask

   // Drop valid, wait out every outstanding result, then give the unit a
   // short pause so it is back in idle before a register write
   task automatic settle_idle();
      req_valid <= 1'b0;
      @(posedge clock);
      while (pending_rsp.size() != 0) @(posedge clock);
      repeat (8) @(posedge clock);
   endtask

   task automatic write_window(input logic [30:0] lo, input logic [30:0] hi);
      settle_idle();
      csr_wr_en <= 1'b1;
      csr_index <= CSR_REGION_FIRST;
      csr_wdata <= lo;
      @(posedge clock);
      csr_index <= CSR_REGION_FINAL;
      csr_wdata <= hi;
      @(posedge clock);
      csr_wr_en <= 1'b0;
      win_first = lo;
      win_last = hi;
   endtask

   // Build one random read and send it. Most reads are well formed
   // (matches with insertions, deletions and skips between them); some
   // carry runs of huge insertions or deletions to drive the sum into
   // saturation, some overrun the op store, the rest are noise.
   task automatic play_random_read();
      req_type         ops[$];
      req_type         op;
      rsp_type         none;
      int              n;
      int              i;
      int unsigned     shape;
      logic [3:0]      k;
      logic [3:0]      run_kind;
      longint unsigned span;
      longint unsigned off;
      logic [30:0]     start_pos;
      none = '0;
      shape = $urandom_range(99);
      if (shape < 10) begin
         run_kind = $urandom_range(1) ? KIND_I : KIND_D;
         ops = {ops, bare_op(any_match(), 28'($urandom_range(20, 1)))};
         n = $urandom_range(12, 9);
         repeat (n)
            ops = {ops, bare_op(run_kind, $urandom_range(1) ? LEN_MAX :
                                28'($urandom_range(LEN_MAX, 28'hf00_0000)))};
         ops = {ops, bare_op(any_match(), 28'($urandom_range(20, 1)))};
      end else if (shape < 25) begin
         n = $urandom_range(8, 1);
         repeat (n) ops = {ops, bare_op(4'($urandom_range(15)), any_len())};
      end else begin
         // a few reads straddle the op store limit
         n = (shape < 31) ? $urandom_range(70, 62) : $urandom_range(12, 1);
         for (i = 0; i < n; i++) begin
            if ((i == 0 || i == n - 1) && $urandom_range(9) == 0)
               k = $urandom_range(1) ? OP_S : OP_H;
            else if (i % 2 == 0)
               k = any_match();
            else
               k = any_gap();
            ops = {ops, bare_op(k, any_len())};
         end
      end

      // place the read so the region usually falls inside it
      span = 0;
      foreach (ops[j])
         if (moves_ref(ops[j].op_kind)) span += ops[j].op_length;
      case ($urandom_range(15))
         0: start_pos = 31'($urandom);
         1: start_pos = (win_first == POS_MAX) ? POS_MAX : win_first + 31'd1;
         default: begin
            off = {$urandom, $urandom} % (span + 1);
            start_pos = (win_first >= off) ? 31'(win_first - off) : '0;
         end
      endcase

      // read_begin on later ops is ignored; fill it with noise
      foreach (ops[j]) begin
         op = ops[j];
         op.read_begin = (j == 0) ? start_pos : 31'($urandom);
         op.final_op = (j == ops.size() - 1);
         send_op(op, 1'b0, none);
      end
   endtask

   // ---------------------------------------------------------------
   // Clock, limit, result checker
   // ---------------------------------------------------------------

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   // Stop a hung run; well above the slowest correct run
   initial begin
      #20_000_000;
      $display("FAILURE");
      $finish;
   end

   // Take result transactions under random stall and check each against
   // the oldest expectation
   initial begin
      rsp_type want;
      rsp_stall <= 1'b0;
      forever begin
         @(posedge clock);
         if (!reset && rsp_valid && !rsp_stall) begin
            if (pending_rsp.size() == 0) begin
               $error("result transaction with no expectation outstanding");
               fault_count++;
            end else begin
               want = pending_rsp.pop_front();
               if (rsp_data.found !== want.found) begin
                  $error("found: expected %0d, actual %0d", want.found, rsp_data.found);
                  fault_count++;
               end
               if (rsp_data.indel_diff !== want.indel_diff) begin
                  $error("indel_diff: expected %0d, actual %0d",
                         want.indel_diff, rsp_data.indel_diff);
                  fault_count++;
               end
            end
         end
         rsp_stall <= (recv_stall_pct != 0) && ($urandom_range(99) < recv_stall_pct);
      end
   end

   // ---------------------------------------------------------------
   // Main sequence
   // ---------------------------------------------------------------

   initial begin
      logic [30:0] lo;
      logic [30:0] hi;
      int          ph;
      int unsigned phase_start;

      req_valid <= 1'b0;
      req_data <= '0;
      csr_wr_en <= 1'b0;
      csr_index <= CSR_REGION_FIRST;
      csr_wdata <= '0;
      reset <= 1'b1;

      held_count = 0;
      dropped = 1'b0;
      origin = '0;
      win_first = '0;
      win_last = '0;
      fault_count = 0;
      ops_sent = 0;
      send_gap_pct = 0;
      recv_stall_pct = 0;

      // Directed script. The window after reset is [0, 0].
      // read covering the region with a single match
      add_row(op_row(KIND_EQ, 28'd5, 31'd0, 1'b1, 1'b1, 1'b1, 32'd0));
      // read starting past the region start
      add_row(op_row(KIND_X, 28'd5, 31'd1, 1'b1, 1'b1, 1'b0, 32'd0));
      // no reference span at all
      add_row(op_row(OP_S, 28'd10, 31'd0, 1'b1, 1'b1, 1'b0, 32'd0));
      // forward scan trims to a leading insertion
      add_row(op_row(KIND_I, 28'd3, 31'd0, 1'b0));
      add_row(op_row(KIND_M, 28'd5, 31'd0, 1'b1, 1'b1, 1'b0, 32'd0));
      add_row(window_row(31'd2, 31'd6));
      // backward scan trims to a trailing deletion
      add_row(op_row(KIND_M, 28'd3, 31'd0, 1'b0));
      add_row(op_row(KIND_D, 28'd10, 31'd0, 1'b1));
      // field extremes; the read origin lies beyond the region
      add_row(op_row(OP_ANY, LEN_MAX, POS_MAX, 1'b0));
      add_row(op_row(OP_P, 28'd0, 31'd0, 1'b0));
      add_row(op_row(OP_H, 28'd1, 31'd0, 1'b1, 1'b1, 1'b0, 32'd0));
      // nine full-length insertions inside the window: saturate high
      add_row(op_row(KIND_M, 28'd3, 31'd0, 1'b0));
      repeat (9) add_row(op_row(KIND_I, LEN_MAX, 31'd0, 1'b0));
      add_row(op_row(KIND_M, 28'd5, 31'd0, 1'b1, 1'b1, 1'b1, INT32_MAX_BITS));
      // inverted window: scans cross, the sum is empty
      add_row(window_row(31'd8, 31'd3));
      add_row(op_row(KIND_EQ, 28'd5, 31'd0, 1'b0));
      add_row(op_row(KIND_I, 28'd4, 31'd0, 1'b0));
      add_row(op_row(OP_N, 28'd2, 31'd0, 1'b0));
      add_row(op_row(KIND_X, 28'd5, 31'd0, 1'b1, 1'b1, 1'b1, 32'd0));

      repeat (12) @(posedge clock);
      reset <= 1'b0;

      foreach (script[r]) begin
         if (script[r].is_window) write_window(script[r].lo, script[r].hi);
         else send_op(script[r].op, script[r].pinned, script[r].want);
      end

      // Random phases: each moves the window and cycles the idle mode
      for (ph = 0; ph < PHASES; ph++) begin
         case (ph)
            0: begin lo = 31'd1000; hi = 31'd1000; end
            1: begin lo = 31'd0; hi = 31'd40; end
            2: begin lo = POS_MAX; hi = POS_MAX; end
            3: begin lo = 31'd700; hi = 31'd650; end
            4: begin lo = 31'd1_500_000_000; hi = 31'd1_500_000_020; end
            5: begin
               lo = 31'($urandom_range(32'h7fff_ff00));
               hi = lo + 31'($urandom_range(60));
            end
            6: begin lo = 31'd0; hi = 31'd0; end
            default: begin lo = POS_MAX - 31'd63; hi = POS_MAX; end
         endcase
         write_window(lo, hi);
         case (ph % 4)
            0: begin send_gap_pct = 0; recv_stall_pct = 0; end
            1: begin send_gap_pct = 49; recv_stall_pct = 0; end
            2: begin send_gap_pct = 0; recv_stall_pct = 49; end
            default: begin send_gap_pct = 18; recv_stall_pct = 18; end
         endcase
         phase_start = ops_sent;
         while (ops_sent - phase_start < OPS_PER_PHASE) play_random_read();
      end

      // Drain, then linger long enough to catch any stray result
      req_valid <= 1'b0;
      @(posedge clock);
      while (pending_rsp.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);

      if (fault_count == 0) begin
         $display("SUCCESS");
      end else begin
         $display("FAILURE");
      end
      $finish;
   end

endmodule
